### rtl/core/nfa_pkg.sv
// Shared types and constants for the NFA match engine.
`timescale 1ns / 1ps
`default_nettype none
package nfa_pkg;

   localparam int DEF_NUM_STATES = 256;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_CHAR  = 2'd2;
   localparam logic [1:0] MODE_END   = 2'd3;

   localparam logic [2:0] KIND_ACCEPT  = 3'd0;
   localparam logic [2:0] KIND_EPSILON = 3'd1;
   localparam logic [2:0] KIND_DOTALL  = 3'd2;
   localparam logic [2:0] KIND_BRANCH  = 3'd3;
   localparam logic [2:0] KIND_SYMBOL  = 3'd4;

   localparam logic [1:0] CSR_START_STATE  = 2'd0;
   localparam logic [1:0] CSR_ACCEPT_STATE = 2'd1;
   localparam logic [1:0] CSR_USED_STATES  = 2'd2;

   localparam int ENTRY_WIDTH = 27;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] entry_index;
      logic [2:0] entry_kind;
      logic [7:0] entry_symbol;
      logic [7:0] first_target;
      logic [7:0] second_target;
      logic [7:0] char_value;
   } req_type;

   typedef struct packed {
      logic accept_now;
      logic any_live;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROOT,
      S_POP,
      S_FETCH,
      S_EXP_A,
      S_EXP_B,
      S_SCAN,
      S_CHECK,
      S_COMMIT,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic load;
      logic init_start;
      logic init_char;
      logic visit_root;
      logic pop;
      logic fetch;
      logic exp_a;
      logic exp_b;
      logic scan_rd;
      logic step;
      logic set_root;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic sp_zero;
      logic scan_done;
      logic scan_active;
      logic scan_match;
   } status_type;

endpackage
`default_nettype wire

### rtl/core/nfa_regex_match_engine_core.sv
// Top level of the Thompson NFA match engine.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction returns one result, strobed on rsp_valid for a single cycle;
// the receiver cannot stall it. Load and end transactions go straight to the
// result. A start transaction walks the epsilon closure of the start state. A
// character transaction sweeps min(used_states, NUM_STATES) entries, reads each
// active entry, and walks the closure from the first target of each entry whose
// symbol matches. The pace is set by the single-read state table RAM and the
// closure stack RAM, which the sequencer walks one entry at a time. busy stays
// high from the accepted start until the result strobe; configuration writes
// take effect at once and belong only in idle periods.
module nfa_regex_match_engine_core #(
   parameter int NUM_STATES = nfa_pkg::DEF_NUM_STATES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire nfa_pkg::req_type req_data,
   output logic                  rsp_valid,
   output nfa_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [8:0]       csr_wdata
);
   import nfa_pkg::*;

   cmd_type    cmd;
   status_type status;

   nfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .mode      (req_data.mode),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   nfa_dp #(.NUM_STATES(NUM_STATES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

### rtl/core/nfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

### rtl/core/nfa_ctrl.sv
// Sequencer for load, start, character and end transactions.
`timescale 1ns / 1ps
`default_nettype none
module nfa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          mode,
   input  wire nfa_pkg::status_type status,
   output logic                     busy,
   output logic                     rsp_valid,
   output nfa_pkg::cmd_type         cmd
);
   import nfa_pkg::*;

   state_type state_ff, state_in;
   logic      is_char_ff, is_char_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         is_char_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         is_char_ff <= is_char_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      is_char_in = is_char_ff;
      cmd        = '0;
      rsp_valid  = 1'b0;
      busy       = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               is_char_in = (mode == MODE_CHAR);
               case (mode)
                  MODE_LOAD: begin
                     cmd.load = 1'b1;
                     state_in = S_REPORT;
                  end
                  MODE_START: begin
                     cmd.init_start = 1'b1;
                     state_in       = S_ROOT;
                  end
                  MODE_CHAR: begin
                     cmd.init_char = 1'b1;
                     state_in      = S_SCAN;
                  end
                  default: state_in = S_REPORT;
               endcase
            end
         end
         S_ROOT: begin
            cmd.visit_root = 1'b1;
            state_in       = S_POP;
         end
         S_POP: begin
            if (status.sp_zero) begin
               state_in = is_char_ff ? S_SCAN : S_COMMIT;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EXP_A;
         end
         S_EXP_A: begin
            cmd.exp_a = 1'b1;
            state_in  = S_EXP_B;
         end
         S_EXP_B: begin
            cmd.exp_b = 1'b1;
            state_in  = S_POP;
         end
         S_SCAN: begin
            if (status.scan_done) begin
               state_in = S_COMMIT;
            end else if (status.scan_active) begin
               cmd.scan_rd = 1'b1;
               state_in    = S_CHECK;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_CHECK: begin
            cmd.step = 1'b1;
            if (status.scan_match) begin
               cmd.set_root = 1'b1;
               state_in     = S_ROOT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_REPORT;
         end
         S_REPORT: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit not followed by result");
endmodule
`default_nettype wire

### rtl/core/nfa_dp.sv
// Datapath: state table, closure stack, active and next sets, CSRs.
`timescale 1ns / 1ps
`default_nettype none
module nfa_dp #(
   parameter int NUM_STATES = nfa_pkg::DEF_NUM_STATES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire nfa_pkg::req_type req_data,
   input  wire nfa_pkg::cmd_type cmd,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [8:0]       csr_wdata,
   output nfa_pkg::status_type   status,
   output nfa_pkg::rsp_type      rsp_data
);
   import nfa_pkg::*;

   localparam int IW = $clog2(NUM_STATES);
   localparam int CW = (IW + 1 > 9) ? IW + 1 : 9;
   localparam logic [CW-1:0] NONE = CW'(NUM_STATES);

   logic [7:0]            start_ff, accept_ff;
   logic [8:0]            used_ff;
   logic [NUM_STATES-1:0] active_ff, next_ff, next_in;
   logic [CW-1:0]         act_min_ff, next_min_ff, next_min_in;
   logic [IW:0]           sp_ff, sp_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [7:0]            root_ff, root_in;
   logic [7:0]            char_ff, char_in;
   logic [CW-1:0]         lim;

   logic [ENTRY_WIDTH-1:0] tbl_rdata;
   logic [IW-1:0]          stk_rdata;
   logic [2:0]             tbl_kind;
   logic [IW-1:0]          tbl_rd_addr;
   logic                   tbl_wr_en;
   logic [CW-1:0]          load_ext;

   logic [7:0]    visit_idx;
   logic          visit_en, visit_ok;
   logic [CW-1:0] visit_ext;
   logic [IW:0]   sp_m1;
   logic [CW-1:0] acc_ext;

   assign lim = (CW'(used_ff) > NONE) ? NONE : CW'(used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 8'd0;
         accept_ff <= 8'd0;
         used_ff   <= 9'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_STATE:  start_ff  <= csr_wdata[7:0];
            CSR_ACCEPT_STATE: accept_ff <= csr_wdata[7:0];
            CSR_USED_STATES:  used_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // State table
   assign load_ext    = CW'(req_data.entry_index);
   assign tbl_wr_en   = cmd.load && (load_ext < NONE);
   assign tbl_rd_addr = cmd.fetch ? stk_rdata : idx_ff[IW-1:0];
   assign tbl_kind    = tbl_rdata[26:24];

   nfa_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(NUM_STATES)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (load_ext[IW-1:0]),
      .wr_data ({req_data.entry_kind, req_data.entry_symbol,
                 req_data.first_target, req_data.second_target}),
      .rd_en   (cmd.fetch || cmd.scan_rd),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rdata)
   );

   // Closure work stack
   always_comb begin
      visit_idx = root_ff;
      visit_en  = 1'b0;
      if (cmd.visit_root) begin
         visit_en = 1'b1;
      end else if (cmd.exp_a) begin
         visit_idx = tbl_rdata[15:8];
         visit_en  = (tbl_kind == KIND_EPSILON) || (tbl_kind == KIND_BRANCH);
      end else if (cmd.exp_b) begin
         visit_idx = tbl_rdata[7:0];
         visit_en  = (tbl_kind == KIND_BRANCH);
      end
   end

   assign visit_ext = CW'(visit_idx);
   assign visit_ok  = visit_en && (visit_ext < lim) && !next_ff[visit_ext[IW-1:0]];
   assign sp_m1     = sp_ff - 1'b1;

   nfa_ram #(.WIDTH(IW), .DEPTH(NUM_STATES)) u_stack (
      .clock   (clock),
      .wr_en   (visit_ok),
      .wr_addr (sp_ff[IW-1:0]),
      .wr_data (visit_ext[IW-1:0]),
      .rd_en   (cmd.pop),
      .rd_addr (sp_m1[IW-1:0]),
      .rd_data (stk_rdata)
   );

   always_comb begin
      next_in     = next_ff;
      next_min_in = next_min_ff;
      sp_in       = sp_ff;
      idx_in      = idx_ff;
      root_in     = root_ff;
      char_in     = char_ff;
      if (cmd.init_start || cmd.init_char) begin
         next_in     = '0;
         next_min_in = NONE;
         sp_in       = '0;
         idx_in      = '0;
         root_in     = start_ff;
         char_in     = req_data.char_value;
      end
      if (visit_ok) begin
         next_in[visit_ext[IW-1:0]] = 1'b1;
         sp_in                      = sp_ff + 1'b1;
         if (visit_ext < next_min_ff) begin
            next_min_in = visit_ext;
         end
      end
      if (cmd.pop) begin
         sp_in = sp_m1;
      end
      if (cmd.step) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.set_root) begin
         root_in = tbl_rdata[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         next_ff     <= '0;
         act_min_ff  <= NONE;
         next_min_ff <= NONE;
         sp_ff       <= '0;
      end else begin
         next_ff     <= next_in;
         next_min_ff <= next_min_in;
         sp_ff       <= sp_in;
         if (cmd.commit) begin
            active_ff  <= next_ff;
            act_min_ff <= next_min_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      root_ff <= root_in;
      char_ff <= char_in;
   end

   assign status.sp_zero     = (sp_ff == '0);
   assign status.scan_done   = (idx_ff >= lim);
   assign status.scan_active = active_ff[idx_ff[IW-1:0]];
   assign status.scan_match  = (tbl_kind == KIND_DOTALL) ||
                               ((tbl_kind == KIND_SYMBOL) && (tbl_rdata[23:16] == char_ff));

   // Lowest active index tracks liveness against the current limit
   assign acc_ext             = CW'(accept_ff);
   assign rsp_data.accept_now = (acc_ext < lim) && active_ff[acc_ext[IW-1:0]];
   assign rsp_data.any_live   = (act_min_ff < lim);

   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= (IW+1)'(NUM_STATES))
      else $error("closure stack overflow");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (active_ff == $past(next_ff)))
      else $error("commit did not copy next set");
   assert property (@(posedge clock) disable iff (reset)
      (next_min_ff == NONE) || next_ff[next_min_ff[IW-1:0]])
      else $error("next-set minimum points at an inactive state");
endmodule
`default_nettype wire
